[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers on clk_i / rst_ni.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked while out of reset
`define MIW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked on every edge, reset included
`define MIW_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

[src/miw_pkg.sv]
// ----------------------------------------------------------------------------
// miw_pkg
// Widths, reset values and register indexes of the interrupt watchdog.
// ----------------------------------------------------------------------------
package miw_pkg;

  localparam int unsigned LineCount   = 256;
  localparam int unsigned LineCmpW    = 11;  // holds LineCount up to 2047

  localparam int unsigned StormW      = 26;
  localparam int unsigned UnprodW     = 8;
  localparam int unsigned PollW       = 10;
  localparam int unsigned LineW       = 8;
  localparam int unsigned CfgDataW    = 26;
  localparam int unsigned CfgIdxW     = 2;

  localparam logic [StormW-1:0]  StormLimitRst   = StormW'(40000000);
  localparam logic [UnprodW-1:0] UnprodLimitRst  = UnprodW'(10);
  localparam logic [PollW-1:0]   DefaultPollRst  = PollW'(4);
  localparam logic [PollW-1:0]   MaxPollRst      = PollW'(250);
  localparam logic [PollW-1:0]   PollMin         = PollW'(1);

  typedef enum logic [CfgIdxW-1:0] {
    CfgStormLimit  = 2'd0,
    CfgUnprodLimit = 2'd1,
    CfgDefaultPoll = 2'd2,
    CfgMaxPoll     = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    OpIrq  = 1'b0,
    OpTick = 1'b1
  } op_e;

  typedef struct packed {
    logic             call_handlers;
    logic             clear_activity;
    logic             disable_line;
    logic [LineW-1:0] line_to_disable;
    logic             anomaly;
    logic [PollW-1:0] poll_interval;
    logic             problem_flag;
  } result_t;

endpackage

[src/miw_if.sv]
// ----------------------------------------------------------------------------
// miw_in_if / miw_out_if
// Valid/ready channels for watchdog requests and results.
// ----------------------------------------------------------------------------
interface miw_in_if
  import miw_pkg::*;
;
  logic             valid;
  logic             ready;
  logic             op;
  logic [LineW-1:0] irq_line;
  logic             activity_seen;
  logic             handlers_productive;

  modport source (output valid, op, irq_line, activity_seen, handlers_productive,
                  input ready);
  modport sink   (input valid, op, irq_line, activity_seen, handlers_productive,
                  output ready);
endinterface

interface miw_out_if
  import miw_pkg::*;
;
  logic             valid;
  logic             ready;
  logic             call_handlers;
  logic             clear_activity;
  logic             disable_line;
  logic [LineW-1:0] line_to_disable;
  logic             anomaly;
  logic [PollW-1:0] poll_interval;
  logic             problem_flag;

  modport source (output valid, call_handlers, clear_activity, disable_line,
                  line_to_disable, anomaly, poll_interval, problem_flag,
                  input ready);
  modport sink   (input valid, call_handlers, clear_activity, disable_line,
                  line_to_disable, anomaly, poll_interval, problem_flag,
                  output ready);
endinterface

[src/missed_interrupt_watchdog.sv]
// The result of a request is registered at the edge that accepts it.
// Throughput: one request per cycle while the result is taken; all state updates in one pass of
//   compare/increment logic between the request handshake and the result register.
// The input stays ready while the result register is empty or being drained.
// Reset (async, active low): counts and pending cleared, poll length 4,
//   registers at their defaults, no result held.
// ----------------------------------------------------------------------------
// missed_interrupt_watchdog
// Counts interrupt events, flags stuck lines, and steers forced handler
// calls and the poll interval on poll ticks.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module missed_interrupt_watchdog
  import miw_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  miw_in_if.sink              in_i,
  miw_out_if.source           out_o
);

  // configuration
  logic [StormW-1:0]  storm_limit_q;
  logic [UnprodW-1:0] unprod_limit_q;
  logic [PollW-1:0]   default_poll_q;
  logic [PollW-1:0]   max_poll_q;

  // watchdog state
  logic [StormW-1:0]  irq_count_q, irq_count_d;
  logic               pending_q, pending_d;
  logic [UnprodW-1:0] unprod_count_q, unprod_count_d;
  logic [PollW-1:0]   poll_len_q, poll_len_d;

  logic               out_valid_q;
  result_t            res_q, res_d;

  logic               in_accept;
  logic [StormW:0]    irq_inc;
  logic [UnprodW:0]   unprod_inc;
  logic [PollW-1:0]   upper;
  logic [PollW:0]     poll_dbl;
  logic [PollW-1:0]   poll_half;
  logic               line_ok;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_accept  = in_i.valid && in_i.ready;

  assign irq_inc    = {1'b0, irq_count_q} + (StormW+1)'(1);
  assign unprod_inc = {1'b0, unprod_count_q} + (UnprodW+1)'(1);
  assign upper      = (max_poll_q == '0) ? PollMin : max_poll_q;
  assign poll_dbl   = {poll_len_q, 1'b0};
  assign poll_half  = poll_len_q >> 1;
  assign line_ok    = {{(LineCmpW-LineW){1'b0}}, in_i.irq_line} < LineCmpW'(LineCount);

  always_comb begin
    irq_count_d    = irq_count_q;
    pending_d      = pending_q;
    unprod_count_d = unprod_count_q;
    poll_len_d     = poll_len_q;
    res_d          = '0;

    if (op_e'(in_i.op) == OpIrq) begin
      if (line_ok) begin
        if (irq_inc > {1'b0, storm_limit_q}) begin
          res_d.disable_line    = 1'b1;
          res_d.line_to_disable = in_i.irq_line;
          irq_count_d           = '0;
        end else begin
          irq_count_d = irq_inc[StormW-1:0];
        end
      end
    end else if (pending_q) begin
      pending_d = 1'b0;
      if (irq_count_q == '0) begin
        // forced handler call
        res_d.call_handlers = 1'b1;
        if (in_i.handlers_productive) begin
          if (unprod_count_q == '0) begin
            poll_len_d = (poll_half == '0) ? PollMin : poll_half;
          end else begin
            unprod_count_d = unprod_count_q - UnprodW'(1);
          end
        end else begin
          if (unprod_inc > {1'b0, unprod_limit_q}) begin
            res_d.clear_activity = 1'b1;
            irq_count_d          = '0;
            unprod_count_d       = '0;
          end else begin
            unprod_count_d = unprod_inc[UnprodW-1:0];
          end
          poll_len_d = (poll_dbl > {1'b0, upper}) ? upper : poll_dbl[PollW-1:0];
        end
      end else begin
        res_d.clear_activity = 1'b1;
        irq_count_d          = '0;
      end
    end else if (irq_count_q != '0) begin
      // normal interrupt activity since last tick
      res_d.anomaly        = !in_i.activity_seen;
      res_d.clear_activity = 1'b1;
      irq_count_d          = '0;
      unprod_count_d       = '0;
      poll_len_d           = (default_poll_q == '0) ? PollMin : default_poll_q;
    end else if (in_i.activity_seen) begin
      pending_d = 1'b1;
    end

    res_d.poll_interval = poll_len_d;
    res_d.problem_flag  = pending_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      storm_limit_q  <= StormLimitRst;
      unprod_limit_q <= UnprodLimitRst;
      default_poll_q <= DefaultPollRst;
      max_poll_q     <= MaxPollRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgStormLimit:  storm_limit_q  <= cfg_wdata_i[StormW-1:0];
        CfgUnprodLimit: unprod_limit_q <= cfg_wdata_i[UnprodW-1:0];
        CfgDefaultPoll: default_poll_q <= cfg_wdata_i[PollW-1:0];
        CfgMaxPoll:     max_poll_q     <= cfg_wdata_i[PollW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      irq_count_q    <= '0;
      pending_q      <= 1'b0;
      unprod_count_q <= '0;
      poll_len_q     <= DefaultPollRst;
      out_valid_q    <= 1'b0;
    end else begin
      if (in_accept) begin
        irq_count_q    <= irq_count_d;
        pending_q      <= pending_d;
        unprod_count_q <= unprod_count_d;
        poll_len_q     <= poll_len_d;
        out_valid_q    <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.call_handlers   = res_q.call_handlers;
  assign out_o.clear_activity  = res_q.clear_activity;
  assign out_o.disable_line    = res_q.disable_line;
  assign out_o.line_to_disable = res_q.line_to_disable;
  assign out_o.anomaly         = res_q.anomaly;
  assign out_o.poll_interval   = res_q.poll_interval;
  assign out_o.problem_flag    = res_q.problem_flag;

  // the register is unknown until the first reset edge
  `MIW_ASSERT_ALWAYS(a_poll_nonzero, !rst_ni || poll_len_q != '0,
                     "poll length reached zero")
  `MIW_ASSERT(a_disable_alone, out_valid_q && res_q.disable_line |->
              !res_q.call_handlers && !res_q.clear_activity && !res_q.anomaly,
              "disable mixed with tick result")
  `MIW_ASSERT(a_anomaly_clears, out_valid_q && res_q.anomaly |->
              res_q.clear_activity && !res_q.problem_flag, "anomaly without clear")
  `MIW_ASSERT(a_call_ends_pending, in_accept && pending_q && in_i.op == OpTick |=>
              !pending_q, "pending survived a tick")

endmodule
